// ===== design/image_gradient_vector_field_top_macros.svh =====
// Assertion macros for the image gradient vector field block.
// Used by the port checker; each macro samples on clk and is disabled in reset.
`ifndef IMAGE_GRADIENT_VECTOR_FIELD_TOP_MACROS_SVH
`define IMAGE_GRADIENT_VECTOR_FIELD_TOP_MACROS_SVH

// Plain property, checked at every edge out of reset
`define IGVF_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define IGVF_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define IGVF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/igvf_pkg.sv =====
// Shared types and constants for the image gradient vector field block.
// No dependencies; used by every module of the block.
package igvf_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_HEIGHT = 1024;

    localparam int PIXEL_W   = 8;
    localparam int DIM_W     = 11;
    localparam int GAIN_W    = 16;
    localparam int CFG_W     = 16;
    localparam int COORD_W   = 10;
    localparam int GRAD_W    = 11;
    localparam int FORCE_W   = 26;
    localparam int PROD_W    = GRAD_W + GAIN_W;
    localparam int OUT_DATA_W = 2 * COORD_W + 2 * FORCE_W;

    localparam int DEF_FRAME_WIDTH  = 64;
    localparam int DEF_FRAME_HEIGHT = 64;
    localparam int MIN_DIM          = 3;
    localparam logic signed [GAIN_W-1:0] DEF_STRENGTH = 16'sd256;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);

    typedef enum logic [1:0] {
        REG_FRAME_WIDTH   = 2'd0,
        REG_FRAME_HEIGHT  = 2'd1,
        REG_TOWARD_BRIGHT = 2'd2,
        REG_STRENGTH      = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic                     toward_bright;
        logic signed [GAIN_W-1:0] strength;
    } gain_cfg_t;

    typedef struct packed {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [GRAD_W-1:0] gx;
        logic signed [GRAD_W-1:0] gy;
        logic                     last;
    } grad_word_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fifo_status_t;

endpackage

// ===== design/igvf_front.sv =====
// Front end: pixel intake, row/column counters, line store memory, 3x3 window
// and raw Prewitt differences. Depends on igvf_pkg.
module igvf_front #(
    parameter int MAX_WIDTH  = igvf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = igvf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            restart,
    input  logic [$clog2(MAX_WIDTH)-1:0]    wlast,
    input  logic [$clog2(MAX_HEIGHT)-1:0]   hlast,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [igvf_pkg::PIXEL_W-1:0]    pixel,
    input  igvf_pkg::fifo_status_t          fifo_status,
    output logic                            push,
    output igvf_pkg::grad_word_t            word
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int PW = igvf_pkg::PIXEL_W;
    localparam int SW = PW + 2;

    // each entry: upper row in the high byte, middle row in the low byte
    logic [2*PW-1:0] lines_mem [MAX_WIDTH];
    logic [2*PW-1:0] rd_data_reg;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;

    logic          s1_valid_reg, s1_valid_next;
    logic [CW-1:0] s1_col_reg;
    logic [RW-1:0] s1_row_reg;
    logic [PW-1:0] s1_bot_reg;
    logic          s1_emit_reg;
    logic          s1_last_reg;

    logic [PW-1:0] win_reg [6];

    logic          accept;
    logic          s1_adv;
    logic [PW-1:0] top, mid;
    logic [SW-1:0] left, right, upper, lower;

    assign s1_adv   = s1_valid_reg && (!s1_emit_reg || !fifo_status.full);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign accept   = s_tvalid && s_tready;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (restart)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == wlast)
            begin
                col_next = '0;
                row_next = (row_reg == hlast) ? '0 : row_reg + RW'(1);
            end
            else
            begin
                col_next = col_reg + CW'(1);
            end
        end
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            for (int i = 0; i < 6; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else
        begin
            col_reg      <= col_next;
            row_reg      <= row_next;
            s1_valid_reg <= s1_valid_next;
            if (s1_adv)
            begin
                win_reg[0] <= win_reg[3];
                win_reg[1] <= win_reg[4];
                win_reg[2] <= win_reg[5];
                win_reg[3] <= top;
                win_reg[4] <= mid;
                win_reg[5] <= s1_bot_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg  <= col_reg;
            s1_row_reg  <= row_reg;
            s1_bot_reg  <= pixel;
            s1_emit_reg <= (col_reg >= CW'(2)) && (row_reg >= RW'(2));
            s1_last_reg <= (col_reg == wlast) && (row_reg == hlast);
        end
    end

    // one read at intake, one write as the word leaves stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            rd_data_reg <= lines_mem[col_reg];
        end
        if (s1_adv)
        begin
            lines_mem[s1_col_reg] <= {rd_data_reg[PW-1:0], s1_bot_reg};
        end
    end

    assign top = rd_data_reg[2*PW-1:PW];
    assign mid = rd_data_reg[PW-1:0];

    assign left  = SW'(win_reg[0]) + SW'(win_reg[1]) + SW'(win_reg[2]);
    assign right = SW'(top) + SW'(mid) + SW'(s1_bot_reg);
    assign upper = SW'(win_reg[0]) + SW'(win_reg[3]) + SW'(top);
    assign lower = SW'(win_reg[2]) + SW'(win_reg[5]) + SW'(s1_bot_reg);

    assign push = s1_adv && s1_emit_reg;

    always_comb
    begin
        word.col  = igvf_pkg::COORD_W'(s1_col_reg - CW'(1));
        word.row  = igvf_pkg::COORD_W'(s1_row_reg - RW'(1));
        word.gx   = igvf_pkg::GRAD_W'(left) - igvf_pkg::GRAD_W'(right);
        word.gy   = igvf_pkg::GRAD_W'(upper) - igvf_pkg::GRAD_W'(lower);
        word.last = s1_last_reg;
    end

endmodule

// ===== design/igvf_fifo.sv =====
// Short queue of gradient words between the front end and the gain stage.
// Depends on igvf_pkg.
module igvf_fifo (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  igvf_pkg::grad_word_t   push_word,
    input  logic                   pop,
    output igvf_pkg::grad_word_t   pop_word,
    output igvf_pkg::fifo_status_t status
);

    localparam int DEPTH = igvf_pkg::FIFO_DEPTH;
    localparam int PW    = igvf_pkg::FIFO_PW;

    igvf_pkg::grad_word_t slots_reg [DEPTH];

    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PW:0]   count_reg, count_next;

    assign status.full  = (count_reg == (PW+1)'(DEPTH));
    assign status.empty = (count_reg == '0);
    assign pop_word     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + (PW+1)'(1);
            2'b01:   count_next = count_reg - (PW+1)'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

// ===== design/igvf_back.sv =====
// Back end: direction select, Q8.8 gain multiply and the output register.
// Depends on igvf_pkg.
module igvf_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  igvf_pkg::gain_cfg_t                  gain_cfg,
    input  igvf_pkg::fifo_status_t               fifo_status,
    input  igvf_pkg::grad_word_t                 word,
    output logic                                 pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [igvf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast
);

    localparam int GW = igvf_pkg::GRAD_W;
    localparam int XW = igvf_pkg::PROD_W;
    localparam int FW = igvf_pkg::FORCE_W;
    localparam int KW = igvf_pkg::COORD_W;

    logic                 out_valid_reg, out_valid_next;
    logic [KW-1:0]        col_reg, row_reg;
    logic signed [FW-1:0] fx_reg, fy_reg;
    logic                 last_reg;

    logic signed [GW-1:0] gx_dir, gy_dir;
    logic signed [XW-1:0] prod_x, prod_y;

    assign pop = !fifo_status.empty && (!out_valid_reg || m_tready);

    assign gx_dir = gain_cfg.toward_bright ? -word.gx : word.gx;
    assign gy_dir = gain_cfg.toward_bright ? -word.gy : word.gy;
    assign prod_x = XW'(gx_dir) * XW'(gain_cfg.strength);
    assign prod_y = XW'(gy_dir) * XW'(gain_cfg.strength);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            col_reg  <= word.col;
            row_reg  <= word.row;
            fx_reg   <= FW'(prod_x);
            fy_reg   <= FW'(prod_y);
            last_reg <= word.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {fy_reg, fx_reg, row_reg, col_reg};
    assign m_tlast  = last_reg;

endmodule

// ===== design/image_gradient_vector_field_top.sv =====
// Image gradient vector field: top level with configuration registers.
// Depends on igvf_pkg, igvf_front, igvf_fifo and igvf_back.
//
// Takes 8-bit grey pixels in raster order and returns, for every interior
// pixel, a Prewitt gradient vector scaled by a signed Q8.8 gain; border
// pixels give no word. The input side sustains one pixel per clock while the
// queue is not full, limited by the single line store memory (MAX_WIDTH x 16
// bits, one read and one write per clock). A word passes from the pixel that
// completes its window through intake/memory read, window and differences,
// and gain multiply into the output register; a four-word queue lets the two
// halves stall independently. The line store needs no clearing after reset.
// Writing frame width or height restarts the frame at pixel (0, 0).
module image_gradient_vector_field_top #(
    parameter int MAX_WIDTH  = igvf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = igvf_pkg::DEF_MAX_HEIGHT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 wr_en,
    input  logic [1:0]                           wr_index,
    input  logic [igvf_pkg::CFG_W-1:0]           wr_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [igvf_pkg::PIXEL_W-1:0]         s_tdata,  // pixel[7:0]
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // cell_col[9:0], cell_row[19:10], force_x[45:20], force_y[71:46]
    output logic [igvf_pkg::OUT_DATA_W-1:0]      m_tdata,
    output logic                                 m_tlast   // frame_last
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int W_RST = (igvf_pkg::DEF_FRAME_WIDTH > MAX_WIDTH)
                           ? MAX_WIDTH : igvf_pkg::DEF_FRAME_WIDTH;
    localparam int H_RST = (igvf_pkg::DEF_FRAME_HEIGHT > MAX_HEIGHT)
                           ? MAX_HEIGHT : igvf_pkg::DEF_FRAME_HEIGHT;

    logic [CW-1:0]        wlast_reg, wlast_next;
    logic [RW-1:0]        hlast_reg, hlast_next;
    igvf_pkg::gain_cfg_t  gain_cfg_reg, gain_cfg_next;
    logic                 restart;

    logic [31:0]          wr_dim;
    logic [CW-1:0]        wlast_clamped;
    logic [RW-1:0]        hlast_clamped;

    igvf_pkg::fifo_status_t fifo_status;
    igvf_pkg::grad_word_t   push_word, pop_word;
    logic                   push, pop;

    assign wr_dim = 32'(wr_data[igvf_pkg::DIM_W-1:0]);

    always_comb
    begin
        if (wr_dim < 32'(igvf_pkg::MIN_DIM))
        begin
            wlast_clamped = CW'(igvf_pkg::MIN_DIM - 1);
            hlast_clamped = RW'(igvf_pkg::MIN_DIM - 1);
        end
        else
        begin
            wlast_clamped = (wr_dim > 32'(MAX_WIDTH)) ? CW'(MAX_WIDTH - 1)
                                                      : CW'(wr_dim - 32'd1);
            hlast_clamped = (wr_dim > 32'(MAX_HEIGHT)) ? RW'(MAX_HEIGHT - 1)
                                                       : RW'(wr_dim - 32'd1);
        end
    end

    always_comb
    begin
        wlast_next    = wlast_reg;
        hlast_next    = hlast_reg;
        gain_cfg_next = gain_cfg_reg;
        restart       = 1'b0;
        if (wr_en)
        begin
            unique case (igvf_pkg::reg_index_t'(wr_index))
                igvf_pkg::REG_FRAME_WIDTH:
                begin
                    wlast_next = wlast_clamped;
                    restart    = 1'b1;
                end
                igvf_pkg::REG_FRAME_HEIGHT:
                begin
                    hlast_next = hlast_clamped;
                    restart    = 1'b1;
                end
                igvf_pkg::REG_TOWARD_BRIGHT:
                begin
                    gain_cfg_next.toward_bright = wr_data[0];
                end
                igvf_pkg::REG_STRENGTH:
                begin
                    gain_cfg_next.strength = wr_data[igvf_pkg::GAIN_W-1:0];
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wlast_reg                  <= CW'(W_RST - 1);
            hlast_reg                  <= RW'(H_RST - 1);
            gain_cfg_reg.toward_bright <= 1'b0;
            gain_cfg_reg.strength      <= igvf_pkg::DEF_STRENGTH;
        end
        else
        begin
            wlast_reg    <= wlast_next;
            hlast_reg    <= hlast_next;
            gain_cfg_reg <= gain_cfg_next;
        end
    end

    igvf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .wlast       (wlast_reg),
        .hlast       (hlast_reg),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .pixel       (s_tdata),
        .fifo_status (fifo_status),
        .push        (push),
        .word        (push_word)
    );

    igvf_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_word (push_word),
        .pop       (pop),
        .pop_word  (pop_word),
        .status    (fifo_status)
    );

    igvf_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .gain_cfg    (gain_cfg_reg),
        .fifo_status (fifo_status),
        .word        (pop_word),
        .pop         (pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast)
    );

endmodule

// ===== design/igvf_checker.sv =====
// Port-level checks on the result stream of the gradient block, and the bind
// that attaches them to the top level. Depends on the assertion macro header.
`include "image_gradient_vector_field_top_macros.svh"

module igvf_checker #(
    parameter int MAX_WIDTH  = igvf_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = igvf_pkg::DEF_MAX_HEIGHT
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [igvf_pkg::OUT_DATA_W-1:0] m_tdata,
    input logic                            m_tlast
);

    localparam logic signed [igvf_pkg::FORCE_W-1:0] FORCE_MAX = 26'sd25067520;

    logic signed [igvf_pkg::FORCE_W-1:0] force_x, force_y;
    logic                                wide_frame;

    assign force_x    = m_tdata[45:20];
    assign force_y    = m_tdata[71:46];
    assign wide_frame = (MAX_WIDTH > 1024) || (MAX_HEIGHT > 1024);

    `IGVF_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

    `IGVF_ASSERT_IMPL(a_interior_cell, m_tvalid && !wide_frame, (m_tdata[9:0] != 10'd0) && (m_tdata[19:10] != 10'd0), "border cell emitted")

    `IGVF_ASSERT_IMPL(a_force_x_range, m_tvalid, (force_x <= FORCE_MAX) && (force_x >= -FORCE_MAX), "force_x beyond gradient range")

    `IGVF_ASSERT_IMPL(a_force_y_range, m_tvalid, (force_y <= FORCE_MAX) && (force_y >= -FORCE_MAX), "force_y beyond gradient range")

endmodule

bind image_gradient_vector_field_top igvf_checker #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
) u_igvf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/tb.sv =====
// Testbench for image_gradient_vector_field_top: raster pixel stream in, gradient words out.
// Needs igvf_pkg and the design files. A tracker class predicts every word and checks the
// output stream, while plain tasks drive the pixel and register ports.
`timescale 1ns / 100ps

module tb;
    import igvf_pkg::*;

    typedef struct {
        logic [COORD_W-1:0]       col;
        logic [COORD_W-1:0]       row;
        logic signed [FORCE_W-1:0] fx;
        logic signed [FORCE_W-1:0] fy;
        logic                     last;
    } vec_word_t;

    class gradient_tracker;
        logic [DIM_W-1:0]         width_reg;
        logic [DIM_W-1:0]         height_reg;
        logic                     bright_reg;
        logic signed [GAIN_W-1:0] gain_reg;
        logic [PIXEL_W-1:0]       upper_line [DEF_MAX_WIDTH];
        logic [PIXEL_W-1:0]       middle_line[DEF_MAX_WIDTH];
        logic [PIXEL_W-1:0]       win[6];
        int unsigned              col_cnt;
        int unsigned              row_cnt;
        vec_word_t                pending_vectors[$];
        int                       errors;

        function new();
            width_reg  = DIM_W'(DEF_FRAME_WIDTH);
            height_reg = DIM_W'(DEF_FRAME_HEIGHT);
            bright_reg = 1'b0;
            gain_reg   = DEF_STRENGTH;
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
            end
            foreach (win[i])
                win[i] = '0;
            col_cnt = 0;
            row_cnt = 0;
            errors  = 0;
        endfunction

        function int unsigned eff_dim(logic [DIM_W-1:0] v, int unsigned hi);
            if (v < MIN_DIM)
                return MIN_DIM;
            if (v > hi)
                return hi;
            return v;
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH @%0t: %s", $realtime, msg);
            errors++;
        endtask

        function void write_reg(reg_index_t idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_FRAME_WIDTH:
                begin
                    width_reg = data[DIM_W-1:0];
                    col_cnt = 0;
                    row_cnt = 0;
                end
                REG_FRAME_HEIGHT:
                begin
                    height_reg = data[DIM_W-1:0];
                    col_cnt = 0;
                    row_cnt = 0;
                end
                REG_TOWARD_BRIGHT: bright_reg = data[0];
                REG_STRENGTH:      gain_reg = data[GAIN_W-1:0];
                default: ;
            endcase
        endfunction

        // Prewitt cell for the window completed by this pixel
        function void note_pixel(logic [PIXEL_W-1:0] bot);
            int unsigned w, h, c, r;
            logic [PIXEL_W-1:0] top, mid;
            int left, right, upper, lower, gx, gy, g;
            logic signed [31:0] px, py;
            vec_word_t v;
            w = eff_dim(width_reg, DEF_MAX_WIDTH);
            h = eff_dim(height_reg, DEF_MAX_HEIGHT);
            c = col_cnt;
            r = row_cnt;
            if (c >= w)
                c = w - 1;
            if (r >= h)
                r = h - 1;
            top = upper_line[c];
            mid = middle_line[c];
            if (c >= 2 && r >= 2)
            begin
                left  = int'(win[0]) + int'(win[1]) + int'(win[2]);
                right = int'(top) + int'(mid) + int'(bot);
                upper = int'(win[0]) + int'(win[3]) + int'(top);
                lower = int'(win[2]) + int'(win[5]) + int'(bot);
                gx = left - right;
                gy = upper - lower;
                g  = int'(gain_reg);
                if (bright_reg)
                begin
                    gx = -gx;
                    gy = -gy;
                end
                px = gx * g;
                py = gy * g;
                v.col  = COORD_W'(c - 1);
                v.row  = COORD_W'(r - 1);
                v.fx   = px[FORCE_W-1:0];
                v.fy   = py[FORCE_W-1:0];
                v.last = (c == w - 1 && r == h - 1);
                pending_vectors = {pending_vectors, v};
            end
            win[0] = win[3];
            win[1] = win[4];
            win[2] = win[5];
            win[3] = top;
            win[4] = mid;
            win[5] = bot;
            upper_line[c]  = mid;
            middle_line[c] = bot;
            if (c + 1 >= w)
            begin
                col_cnt = 0;
                row_cnt = (r + 1 >= h) ? 0 : r + 1;
            end
            else
            begin
                col_cnt = c + 1;
                row_cnt = r;
            end
        endfunction

        task check_word(logic [COORD_W-1:0] col, logic [COORD_W-1:0] row,
                        logic [FORCE_W-1:0] fx, logic [FORCE_W-1:0] fy,
                        logic last);
            vec_word_t e;
            if (pending_vectors.size() == 0)
            begin
                report_mismatch($sformatf("unexpected word col %0d row %0d", col, row));
                return;
            end
            e = pending_vectors.pop_front();
            if (col !== e.col)
                report_mismatch($sformatf("cell_col %0d, want %0d", col, e.col));
            if (row !== e.row)
                report_mismatch($sformatf("cell_row %0d, want %0d", row, e.row));
            if (fx !== e.fx)
                report_mismatch($sformatf("force_x %0d, want %0d at (%0d,%0d)",
                                          $signed(fx), e.fx, e.col, e.row));
            if (fy !== e.fy)
                report_mismatch($sformatf("force_y %0d, want %0d at (%0d,%0d)",
                                          $signed(fy), e.fy, e.col, e.row));
            if (last !== e.last)
                report_mismatch($sformatf("frame_last %b, want %b at (%0d,%0d)",
                                          last, e.last, e.col, e.row));
        endtask
    endclass

    logic                    clk;
    logic                    rst_n;
    logic                    wr_en;
    logic [1:0]              wr_index;
    logic [CFG_W-1:0]        wr_data;
    logic                    s_tvalid;
    logic                    s_tready;
    logic [PIXEL_W-1:0]      s_tdata;
    logic                    m_tvalid;
    logic                    m_tready;
    logic [OUT_DATA_W-1:0]   m_tdata;
    logic                    m_tlast;

    gradient_tracker sb;
    int unsigned     cur_w;
    int unsigned     cur_h;
    int              burst_left;
    int              hold_left;
    bit              hold_req;
    int              mode_left;
    int              ready_pct;

    image_gradient_vector_field_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    initial
    begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // Receiver: ready pattern changes mode at random intervals, plus one long hold-off
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready = 1'b0;
            hold_left--;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_left = 400;
            m_tready  = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                case ($urandom_range(0, 3))
                    0: ready_pct = 100;
                    1: ready_pct = 75;
                    2: ready_pct = 50;
                    default: ready_pct = 25;
                endcase
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            m_tready = ($urandom_range(1, 100) <= ready_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && sb != null && m_tvalid && m_tready)
            sb.check_word(m_tdata[COORD_W-1:0], m_tdata[2*COORD_W-1:COORD_W],
                          m_tdata[2*COORD_W+FORCE_W-1:2*COORD_W],
                          m_tdata[2*COORD_W+2*FORCE_W-1:2*COORD_W+FORCE_W], m_tlast);
    end

    function automatic logic [PIXEL_W-1:0] rand_pixel();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return PIXEL_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] rand_gain();
        case ($urandom_range(0, 7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0100;
            3: return 16'h0000;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    task automatic cfg_write(input reg_index_t idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        wr_en    = 1'b1;
        wr_index = idx;
        wr_data  = data;
        @(posedge clk);
        sb.write_reg(idx, data);
        @(negedge clk);
        wr_en = 1'b0;
    endtask

    task automatic set_geometry(input logic [CFG_W-1:0] wd, input logic [CFG_W-1:0] hd);
        cfg_write(REG_FRAME_WIDTH, wd);
        cfg_write(REG_FRAME_HEIGHT, hd);
        cur_w = sb.eff_dim(wd[DIM_W-1:0], DEF_MAX_WIDTH);
        cur_h = sb.eff_dim(hd[DIM_W-1:0], DEF_MAX_HEIGHT);
    endtask

    task automatic send_pixel(input logic [PIXEL_W-1:0] p);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                                     : $urandom_range(1, 24);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata  = p;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_pixel(p);
    endtask

    task automatic send_row3(input logic [7:0] a, input logic [7:0] b, input logic [7:0] c);
        send_pixel(a);
        send_pixel(b);
        send_pixel(c);
    endtask

    task automatic send_random(input int n);
        repeat (n) send_pixel(rand_pixel());
    endtask

    // Drain: wait until all words are home, then wait out pixels still in flight that give none
    task automatic settle();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending_vectors.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
    endtask

    initial
    begin
        int n;
        int kind;
        int rand_items;
        logic [CFG_W-1:0] wd;
        logic [CFG_W-1:0] hd;
        sb         = new();
        rst_n      = 1'b0;
        wr_en      = 1'b0;
        wr_index   = REG_FRAME_WIDTH;
        wr_data    = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        burst_left = 0;
        hold_left  = 0;
        hold_req   = 1'b0;
        mode_left  = 0;
        ready_pct  = 100;
        cur_w      = DEF_FRAME_WIDTH;
        cur_h      = DEF_FRAME_HEIGHT;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset geometry and gain, three rows
        send_random(3 * cur_w);
        settle();

        // directed: full-scale gradients at gain extremes
        set_geometry(16'd3, 16'd3);
        cfg_write(REG_TOWARD_BRIGHT, 16'hFFFE);
        cfg_write(REG_STRENGTH, 16'h7FFF);
        send_row3(8'd255, 8'd128, 8'd0);
        send_row3(8'd255, 8'd128, 8'd0);
        send_row3(8'd255, 8'd128, 8'd0);
        settle();
        cfg_write(REG_TOWARD_BRIGHT, 16'h0001);
        cfg_write(REG_STRENGTH, 16'h8000);
        send_row3(8'd0, 8'd128, 8'd255);
        send_row3(8'd0, 8'd128, 8'd255);
        send_row3(8'd0, 8'd128, 8'd255);
        send_row3(8'd255, 8'd255, 8'd255);
        send_row3(8'd128, 8'd128, 8'd128);
        send_row3(8'd0, 8'd0, 8'd0);
        settle();

        rand_items = 0;
        while (rand_items < 350)
        begin
            kind = $urandom_range(0, 9);
            if (kind <= 6)
            begin
                wd = {5'($urandom), 11'($urandom_range(3, 12))};
                hd = {5'($urandom), 11'($urandom_range(3, 8))};
                if ($urandom_range(0, 9) == 0)
                    wd[DIM_W-1:0] = 11'($urandom_range(0, 2));
                if ($urandom_range(0, 9) == 0)
                    hd[DIM_W-1:0] = 11'($urandom_range(0, 2));
                set_geometry(wd, hd);
                cfg_write(REG_TOWARD_BRIGHT, CFG_W'($urandom));
                cfg_write(REG_STRENGTH, rand_gain());
                n = cur_w * cur_h * $urandom_range(1, 2);
                if ($urandom_range(0, 4) == 0)
                    n = $urandom_range(1, n);
            end
            else
            begin
                if (kind != 8)
                    cfg_write(REG_TOWARD_BRIGHT, CFG_W'($urandom));
                if (kind != 7)
                    cfg_write(REG_STRENGTH, rand_gain());
                n = $urandom_range(1, 40);
            end
            send_random(n);
            rand_items += n;
            settle();
        end

        // long output hold-off part way through a frame, so the input stalls
        set_geometry(16'd12, 16'd8);
        cfg_write(REG_TOWARD_BRIGHT, 16'd0);
        cfg_write(REG_STRENGTH, rand_gain());
        send_random(30);
        hold_req = 1'b1;
        send_random(66);
        settle();

        // tallest frame, partly, with a gain change part way down
        set_geometry(16'd3, 16'd1024);
        cfg_write(REG_STRENGTH, rand_gain());
        send_random(180);
        settle();
        cfg_write(REG_TOWARD_BRIGHT, 16'd1);
        cfg_write(REG_STRENGTH, rand_gain());
        send_random(60);
        settle();

        repeat (20) @(posedge clk);
        if (sb.pending_vectors.size() != 0)
            sb.report_mismatch($sformatf("%0d words never arrived", sb.pending_vectors.size()));
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+design
design/igvf_pkg.sv
design/igvf_front.sv
design/igvf_fifo.sv
design/igvf_back.sv
design/image_gradient_vector_field_top.sv
design/igvf_checker.sv
verif/tb.sv
